[hw/rtl/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned PrioW  = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned StatW  = 2;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [PrioW-1:0] prio;
    logic [TagW-1:0]         tag;
  } entry_t;

  typedef struct packed {
    logic push;  // insert new word
    logic pop;   // shift toward head
  } cell_ctrl_t;

endpackage

[hw/rtl/ssp_cell.sv]
// ----------------------------------------------------------------------------
// ssp_cell
// One slot of the sorted chain: compares, then keeps, loads or shifts.
// ----------------------------------------------------------------------------
module ssp_cell (
  input  logic               clk_i,
  input  ssp_pkg::cell_ctrl_t ctrl_i,
  input  logic               occ_i,      // slot holds a valid entry
  input  logic               at_left_i,  // left neighbor is at/after insert point
  input  ssp_pkg::entry_t    new_i,
  input  ssp_pkg::entry_t    left_i,
  input  ssp_pkg::entry_t    right_i,
  output ssp_pkg::entry_t    entry_o,
  output logic               at_o
);
  import ssp_pkg::*;

  entry_t entry_q, entry_d;

  // at or after the insert point: empty, or strictly greater than new word
  assign at_o = !occ_i || (entry_q.prio > new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      entry_d = right_i;
    end else if (ctrl_i.push && at_o) begin
      entry_d = at_left_i ? left_i : new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[hw/rtl/stable_sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Result: each accepted input word is registered as a result word in the next cycle.
// Throughput: one push or pop per cycle while the master stream takes results; every cell compares and shifts at once.
// Reset: entry count cleared to zero, output register empty; slot contents
// are not reset and are only read below the count.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // new_priority[31:0], new_tag[47:32]
  input  logic [0:0]   s_axis_tuser,   // req_type[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // popped_priority[31:0], popped_tag[47:32],
                                       // head_priority[79:48], head_tag[95:80],
                                       // entry_count[100:96], zero pad
  output logic [1:0]   m_axis_tuser    // status[1:0]
);
  import ssp_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_vld_q;
  logic [103:0]    out_data_q, out_data_d;
  logic [1:0]      out_stat_q, out_stat_d;

  entry_t     new_entry, head_d, pop_d;
  entry_t     cells [Depth];
  logic       at [Depth];
  cell_ctrl_t ctrl;
  logic       acc, is_pop, full, empty;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign acc    = s_axis_tvalid && s_axis_tready;
  assign is_pop = s_axis_tuser[0];
  assign full   = (cnt_q == CntW'(Depth));
  assign empty  = (cnt_q == '0);

  assign new_entry.prio = s_axis_tdata[31:0];
  assign new_entry.tag  = s_axis_tdata[47:32];

  assign ctrl.push = acc && !is_pop && !full;
  assign ctrl.pop  = acc && is_pop && !empty;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   at_left;
    if (i == 0) begin : g_first
      assign left_e  = new_entry;
      assign at_left = 1'b0;
    end else begin : g_mid
      assign left_e  = cells[i-1];
      assign at_left = at[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cells[i+1];
    end
    ssp_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (CntW'(i) < cnt_q),
      .at_left_i (at_left),
      .new_i     (new_entry),
      .left_i    (left_e),
      .right_i   (right_e),
      .entry_o   (cells[i]),
      .at_o      (at[i])
    );
  end

  always_comb begin
    cnt_d      = cnt_q;
    out_stat_d = ST_OK;
    pop_d      = '0;
    head_d     = empty ? entry_t'('0) : cells[0];
    if (is_pop) begin
      if (empty) begin
        out_stat_d = ST_EMPTY;
      end else begin
        pop_d  = cells[0];
        cnt_d  = cnt_q - CntW'(1);
        head_d = (cnt_q > CntW'(1)) ? cells[1] : entry_t'('0);
      end
    end else begin
      if (full) begin
        out_stat_d = ST_FULL;
      end else begin
        cnt_d  = cnt_q + CntW'(1);
        head_d = at[0] ? new_entry : cells[0];
      end
    end
    out_data_d = {3'b000, cnt_d, head_d.tag, head_d.prio, pop_d.tag, pop_d.prio};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        cnt_q     <= cnt_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_data_q <= out_data_d;
      out_stat_q <= out_stat_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

endmodule

[tb/stable_sorted_priority_queue_test.sv]
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_test
// Self-checking bench for the stable sorted priority queue. Push and pop
// words go in on the slave stream; a local sorted list predicts each result
// word, which is compared field by field as it leaves the master stream.
// Directed words cover empty pops, priority extremes and ties; random
// phases fill to or past full, drain to or past empty and mix pushes and
// pops, with random gaps and stalls on both streams but in a back-to-back phase.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_test;
  import ssp_pkg::*;

  localparam logic        REQ_PUSH   = 1'b0;
  localparam logic        REQ_POP    = 1'b1;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [StatW-1:0]        status;
    logic signed [PrioW-1:0] pop_prio;
    logic [TagW-1:0]         pop_tag;
    logic signed [PrioW-1:0] head_prio;
    logic [TagW-1:0]         head_tag;
    logic [CntW-1:0]         count;
  } queue_result_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata  = '0;   // new_priority[31:0], new_tag[47:32]
  logic [0:0]   s_axis_tuser  = '0;   // req_type[0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;         // popped_priority[31:0], popped_tag[47:32],
                                      // head_priority[79:48], head_tag[95:80],
                                      // entry_count[100:96], zero pad
  logic [1:0]   m_axis_tuser;         // status[1:0]

  entry_t        sorted_entries[$];
  queue_result_t expected_results[$];
  int unsigned   errors      = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   ready_hold  = 0;
  bit            pace        = 1'b1;

  stable_sorted_priority_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    if (!pace) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  // Apply one request to the sorted list and return the resulting word.
  function automatic queue_result_t queue_apply(input logic req,
                                                input logic [PrioW-1:0] prio,
                                                input logic [TagW-1:0] tag);
    queue_result_t res;
    entry_t        e;
    int            pos;
    res = '0;
    if (req == REQ_PUSH) begin
      if (sorted_entries.size() >= Depth) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        // stable: skip every entry with equal or smaller priority
        while (pos < sorted_entries.size() &&
               !($signed(sorted_entries[pos].prio) > $signed(prio)))
          pos++;
        e.prio = prio;
        e.tag  = tag;
        sorted_entries.insert(pos, e);
        res.status = ST_OK;
      end
    end else begin
      if (sorted_entries.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        e = sorted_entries.pop_front();
        res.status   = ST_OK;
        res.pop_prio = e.prio;
        res.pop_tag  = e.tag;
      end
    end
    if (sorted_entries.size() > 0) begin
      res.head_prio = sorted_entries[0].prio;
      res.head_tag  = sorted_entries[0].tag;
    end
    res.count = CntW'(sorted_entries.size());
    return res;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Predict on input handshakes, check on output handshakes.
  always @(posedge clk_i) begin : check_words
    queue_result_t got;
    queue_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(queue_apply(s_axis_tuser[0], s_axis_tdata[31:0],
                                               s_axis_tdata[47:32]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status    = m_axis_tuser;
        got.pop_prio  = m_axis_tdata[31:0];
        got.pop_tag   = m_axis_tdata[47:32];
        got.head_prio = m_axis_tdata[79:48];
        got.head_tag  = m_axis_tdata[95:80];
        got.count     = m_axis_tdata[100:96];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          report_field("status", 32'(want.status), 32'(got.status));
          report_field("popped_priority", want.pop_prio, got.pop_prio);
          report_field("popped_tag", 32'(want.pop_tag), 32'(got.pop_tag));
          report_field("head_priority", want.head_prio, got.head_prio);
          report_field("head_tag", 32'(want.head_tag), 32'(got.head_tag));
          report_field("entry_count", 32'(want.count), 32'(got.count));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (ready_hold > 0) ready_hold--;
    else ready_hold = gap_len();
    m_axis_tready <= (ready_hold == 0);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("stable_sorted_priority_queue_test failed");
      $finish;
    end
  end

  task automatic send_word(input logic req, input logic [PrioW-1:0] prio,
                           input logic [TagW-1:0] tag);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {tag, prio};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [PrioW-1:0] rand_prio();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(6) - 3;   // narrow range, many ties
    if (r < 50) begin
      case ($urandom_range(3))
        0:       return 32'h7fff_ffff;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  task automatic send_random(input int unsigned push_pct);
    if ($urandom_range(99) < push_pct) send_word(REQ_PUSH, rand_prio(), TagW'($urandom()));
    else send_word(REQ_POP, $urandom(), TagW'($urandom()));
  endtask

  task automatic test_pop_empty();
    send_word(REQ_POP, 32'h0, 16'h0);
  endtask

  task automatic test_extremes_and_ties();
    send_word(REQ_PUSH, 32'h7fff_ffff, 16'hffff);
    send_word(REQ_PUSH, 32'h8000_0000, 16'h0000);
    send_word(REQ_PUSH, 32'h0000_0000, 16'h1234);
    send_word(REQ_PUSH, 32'hffff_ffff, 16'haaaa);
    send_word(REQ_PUSH, 32'h0001_0000, 16'h0001);
    send_word(REQ_PUSH, 32'h0001_0000, 16'h0002);
    send_word(REQ_PUSH, 32'h0001_0000, 16'h0003);
    send_word(REQ_PUSH, 32'h8000_0000, 16'h5555);
    send_word(REQ_PUSH, 32'h7fff_ffff, 16'h0000);
    repeat (10) send_word(REQ_POP, 32'hffff_ffff, 16'hffff);
  endtask

  // n >= Depth pushes then n or more pops: full or overflow, then empty or empty pops.
  task automatic test_fill_and_drain(input int unsigned rounds);
    int unsigned n;
    repeat (rounds) begin
      n = Depth + $urandom_range(3);
      repeat (n) send_word(REQ_PUSH, rand_prio(), TagW'($urandom()));
      repeat (n + $urandom_range(3)) send_word(REQ_POP, $urandom(), TagW'($urandom()));
    end
  endtask

  task automatic test_random_mixed(input int unsigned blocks);
    int unsigned pct;
    repeat (blocks) begin
      case ($urandom_range(2))
        0:       pct = 30;
        1:       pct = 50;
        default: pct = 70;
      endcase
      repeat (50) send_random(pct);
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    pace = 1'b0;
    repeat (count) send_random(55);
    pace = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pop_empty();
    test_extremes_and_ties();
    test_fill_and_drain(12);
    test_random_mixed(28);
    test_back_to_back(150);
    test_fill_and_drain(2);
    s_axis_tvalid <= 1'b0;
    // let the last accepted word reach the prediction queue
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0)
      $display("stable_sorted_priority_queue_test passed");
    else
      $display("stable_sorted_priority_queue_test failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_cell.sv
hw/rtl/stable_sorted_priority_queue.sv
tb/stable_sorted_priority_queue_test.sv
